// ===== rtl/shtp_pkg.sv =====
package shtp_pkg;

    localparam int unsigned LEN_W = 15;
    localparam int unsigned BYTE_W = 8;

    localparam logic [LEN_W-1:0] LENGTH_LIMIT_RESET = 15'd512;
    localparam logic [LEN_W-1:0] HDR_BYTES = 15'd4;
    localparam logic [BYTE_W-1:0] LEN_HIGH_MASK = 8'h7F;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADLEN  = 2'd2,
        ST_LINKERR = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] channel;
        logic [LEN_W-1:0]  payload_length;
        logic              is_last;
        status_t           status;
    } result_t;

endpackage

// ===== rtl/shtp_parse.sv =====
module shtp_parse (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [shtp_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                                first_in_window,
    input  logic                                link_error,
    input  logic                                cfg_wr_en,
    input  logic [shtp_pkg::LEN_W-1:0]          cfg_wr_data,
    output logic                                res_valid,
    output shtp_pkg::result_t                   res
);

    shtp_pkg::phase_t                phase_reg, phase_next, eff_phase;
    logic [shtp_pkg::LEN_W-1:0]      pos_reg, pos_next, eff_pos;
    logic [shtp_pkg::LEN_W-1:0]      total_reg, total_next, eff_total;
    logic [shtp_pkg::BYTE_W-1:0]     low_reg, low_next, eff_low;
    logic [shtp_pkg::BYTE_W-1:0]     chan_reg, chan_next, eff_chan;
    logic [shtp_pkg::LEN_W-1:0]      limit_reg;
    logic [shtp_pkg::BYTE_W-1:0]     high_masked;
    logic                            len_empty, len_bad, last_byte;

    // A first-byte flag restarts the header, even in the middle of a packet.
    assign eff_phase = first_in_window ? shtp_pkg::PH_HEADER : phase_reg;
    assign eff_pos   = first_in_window ? '0 : pos_reg;
    assign eff_total = first_in_window ? '0 : total_reg;
    assign eff_low   = first_in_window ? '0 : low_reg;
    assign eff_chan  = first_in_window ? '0 : chan_reg;

    assign high_masked = rx_byte & shtp_pkg::LEN_HIGH_MASK;

    // A length of four above a limit below four counts as bad, not empty.
    assign len_bad   = ((eff_total != '0) && (eff_total < shtp_pkg::HDR_BYTES))
                       || (eff_total > limit_reg);
    assign len_empty = (eff_total == '0) || ((eff_total == shtp_pkg::HDR_BYTES) && !len_bad);
    assign last_byte = ({1'b0, eff_pos} + 16'd1) >= {1'b0, eff_total};

    always_comb
    begin
        phase_next = eff_phase;
        unique case (eff_phase) inside
            shtp_pkg::PH_IDLE, shtp_pkg::PH_DONE:
            begin
                phase_next = eff_phase;
            end
            shtp_pkg::PH_HEADER:
            begin
                if (link_error || ((eff_pos[1:0] == 2'd3) && (len_empty || len_bad)))
                    phase_next = shtp_pkg::PH_DONE;
                else if (eff_pos[1:0] == 2'd3)
                    phase_next = shtp_pkg::PH_PAYLOAD;
            end
            shtp_pkg::PH_PAYLOAD:
            begin
                if (link_error || last_byte)
                    phase_next = shtp_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = eff_phase;
            end
        endcase
    end

    always_comb
    begin
        pos_next                = eff_pos;
        total_next              = eff_total;
        low_next                = eff_low;
        chan_next               = eff_chan;
        res_valid               = 1'b0;
        res.payload_byte        = '0;
        res.channel             = eff_chan;
        res.payload_length      = '0;
        res.is_last             = 1'b1;
        res.status              = shtp_pkg::ST_LINKERR;
        unique case (eff_phase) inside
            shtp_pkg::PH_IDLE, shtp_pkg::PH_DONE:
            begin
                res_valid = 1'b0;
            end
            shtp_pkg::PH_HEADER:
            begin
                if (link_error)
                    res_valid = 1'b1;
                else
                begin
                    case (eff_pos[1:0])
                        2'd0:
                        begin
                            low_next = rx_byte;
                            pos_next = 15'd1;
                        end
                        2'd1:
                        begin
                            total_next = {high_masked[6:0], eff_low};
                            pos_next   = 15'd2;
                        end
                        2'd2:
                        begin
                            chan_next = rx_byte;
                            pos_next  = 15'd3;
                        end
                        default:
                        begin
                            pos_next = shtp_pkg::HDR_BYTES;
                            if (len_empty || len_bad)
                            begin
                                res_valid  = 1'b1;
                                res.status = len_empty ? shtp_pkg::ST_EMPTY
                                                       : shtp_pkg::ST_BADLEN;
                            end
                        end
                    endcase
                end
            end
            shtp_pkg::PH_PAYLOAD:
            begin
                res_valid = 1'b1;
                if (!link_error)
                begin
                    res.payload_byte   = rx_byte;
                    res.payload_length = eff_total - shtp_pkg::HDR_BYTES;
                    res.is_last        = last_byte;
                    res.status         = shtp_pkg::ST_DATA;
                    pos_next           = eff_pos + 15'd1;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= shtp_pkg::PH_IDLE;
            pos_reg   <= '0;
            total_reg <= '0;
            low_reg   <= '0;
            chan_reg  <= '0;
            limit_reg <= shtp_pkg::LENGTH_LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                total_reg <= total_next;
                low_reg   <= low_next;
                chan_reg  <= chan_next;
            end
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/shtp_out_reg.sv =====
module shtp_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               res_valid,
    input  shtp_pkg::result_t  res,
    output logic               out_valid,
    input  logic               out_ready,
    output shtp_pkg::result_t  out_res
);

    logic              out_valid_reg, out_valid_next;
    shtp_pkg::result_t res_reg;
    logic              accept;

    // The register may be reloaded in the same cycle as its request leaves.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = res_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/shtp_packet_deframer_top.sv =====
// SHTP packet deframer: takes one received SPI byte per cycle while in_ready is high, with
// first-byte-of-window and link-error flags, parses the four header bytes and passes on
// each payload byte with its channel, payload length and last mark, or one status request
// (empty packet, bad length, link error). A request appears in the next cycle from the
// output register; a new byte is still taken while it waits if out_ready is high in that
// cycle. Only a header byte that ends the packet gives a request; none outside a packet.
// The user must write length_limit via cfg_wr_en/cfg_wr_data only while idle (not checked).
module shtp_packet_deframer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [shtp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        first_in_window,
    input  logic                        link_error,
    input  logic                        cfg_wr_en,
    input  logic [shtp_pkg::LEN_W-1:0]  cfg_wr_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [shtp_pkg::BYTE_W-1:0] payload_byte,
    output logic [shtp_pkg::BYTE_W-1:0] channel,
    output logic [shtp_pkg::LEN_W-1:0]  payload_length,
    output logic                        is_last,
    output logic [1:0]                  status
);

    logic              res_valid;
    shtp_pkg::result_t res;
    shtp_pkg::result_t out_res;

    shtp_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_valid && in_ready),
        .rx_byte         (rx_byte),
        .first_in_window (first_in_window),
        .link_error      (link_error),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .res_valid       (res_valid),
        .res             (res)
    );

    shtp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign payload_byte   = out_res.payload_byte;
    assign channel        = out_res.channel;
    assign payload_length = out_res.payload_length;
    assign is_last        = out_res.is_last;
    assign status         = out_res.status;

endmodule

// ===== rtl/shtp_checker.sv =====
module shtp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [shtp_pkg::BYTE_W-1:0] payload_byte,
    input logic [shtp_pkg::BYTE_W-1:0] channel,
    input logic [shtp_pkg::LEN_W-1:0]  payload_length,
    input logic                        is_last,
    input logic [1:0]                  status
);

    // A stalled request keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(channel)
            && $stable(payload_length) && $stable(is_last) && $stable(status))
        else $error("stalled output request changed");

    // Input is never held off while the output register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != shtp_pkg::ST_DATA) |-> is_last)
        else $error("status request without last mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != shtp_pkg::ST_DATA)
            |-> (payload_byte == '0) && (payload_length == '0))
        else $error("status request carries payload fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == shtp_pkg::ST_DATA) |-> (payload_length != '0))
        else $error("data request with zero payload length");

endmodule

bind shtp_packet_deframer_top shtp_checker u_shtp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .channel        (channel),
    .payload_length (payload_length),
    .is_last        (is_last),
    .status         (status)
);

// ===== bench/deframer_tb_pkg.sv =====
package deframer_tb_pkg;

    import shtp_pkg::*;

    // Tracks the header parse of the deframer and keeps the requests it should produce,
    // oldest first.
    class deframer_scoreboard;

        logic [LEN_W-1:0]  limit;
        phase_t            ph;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  total;
        logic [BYTE_W-1:0] len_lo;
        logic [BYTE_W-1:0] chan;
        result_t           pending[$];
        int unsigned       errors;
        int unsigned       seen[4];

        function new();
            limit = LENGTH_LIMIT_RESET;
            ph = PH_IDLE;
            pos = '0;
            total = '0;
            len_lo = '0;
            chan = '0;
            errors = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void write_limit(logic [LEN_W-1:0] value);
            limit = value;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        function void push(logic [BYTE_W-1:0] data, logic [LEN_W-1:0] plen, logic last,
                           status_t st);
            result_t r;
            r.payload_byte = data;
            r.channel = chan;
            r.payload_length = plen;
            r.is_last = last;
            r.status = st;
            pending.push_back(r);
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic first, logic err);
            logic [BYTE_W-1:0] hi;
            logic              last;
            if (first)
            begin
                ph = PH_HEADER;
                pos = '0;
                total = '0;
                chan = '0;
                len_lo = '0;
            end
            if (ph == PH_IDLE || ph == PH_DONE)
                return;
            if (err)
            begin
                ph = PH_DONE;
                push('0, '0, 1'b1, ST_LINKERR);
                return;
            end
            if (ph == PH_HEADER)
            begin
                case (pos)
                    15'd0:
                    begin
                        len_lo = b;
                        pos = 15'd1;
                    end
                    15'd1:
                    begin
                        hi = b & LEN_HIGH_MASK;
                        total = {hi[6:0], len_lo};
                        pos = 15'd2;
                    end
                    15'd2:
                    begin
                        chan = b;
                        pos = 15'd3;
                    end
                    default:
                    begin
                        // The sequence byte completes the header; the length is judged here.
                        pos = HDR_BYTES;
                        if (total == '0)
                        begin
                            ph = PH_DONE;
                            push('0, '0, 1'b1, ST_EMPTY);
                        end
                        else if (total < HDR_BYTES || total > limit)
                        begin
                            ph = PH_DONE;
                            push('0, '0, 1'b1, ST_BADLEN);
                        end
                        else if (total == HDR_BYTES)
                        begin
                            ph = PH_DONE;
                            push('0, '0, 1'b1, ST_EMPTY);
                        end
                        else
                            ph = PH_PAYLOAD;
                    end
                endcase
                return;
            end
            last = (int'(pos) + 1 >= int'(total));
            push(b, total - HDR_BYTES, last, ST_DATA);
            pos = pos + 15'd1;
            if (last)
                ph = PH_DONE;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("request with nothing expected: status %0d byte %0h",
                       got.status, got.payload_byte);
                errors++;
                return;
            end
            want = pending.pop_front();
            seen[got.status]++;
            if (got.payload_byte !== want.payload_byte)
            begin
                $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                       got.payload_byte);
                errors++;
            end
            if (got.channel !== want.channel)
            begin
                $error("channel: expected %0h, got %0h", want.channel, got.channel);
                errors++;
            end
            if (got.payload_length !== want.payload_length)
            begin
                $error("payload_length: expected %0d, got %0d", want.payload_length,
                       got.payload_length);
                errors++;
            end
            if (got.is_last !== want.is_last)
            begin
                $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== bench/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import shtp_pkg::*;
    import deframer_tb_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1550;
    localparam int unsigned PHASE_BYTES = 200;
    localparam int unsigned STALL_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [BYTE_W-1:0]  rx_byte;
    logic               first_in_window;
    logic               link_error;
    logic               cfg_wr_en;
    logic [LEN_W-1:0]   cfg_wr_data;
    logic               out_valid;
    logic               out_ready;
    logic [BYTE_W-1:0]  payload_byte;
    logic [BYTE_W-1:0]  channel;
    logic [LEN_W-1:0]   payload_length;
    logic               is_last;
    logic [1:0]         status;

    deframer_scoreboard sb = new();

    int unsigned bytes_in;
    int unsigned quiet_cycles;
    int unsigned burst_left;
    int unsigned cycle_no;
    int unsigned stall_left;
    int unsigned settings_used;
    int unsigned phase_idx;
    int unsigned random_base;
    int unsigned phase_end;
    logic [LEN_W-1:0] cur_limit;

    shtp_packet_deframer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .first_in_window (first_in_window),
        .link_error      (link_error),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .channel         (channel),
        .payload_length  (payload_length),
        .is_last         (is_last),
        .status          (status)
    );

    always #5 clk = ~clk;

    // Monitor and watchdog. The result is checked before the byte of the same edge is
    // noted, since any request on the output belongs to an earlier byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result('{payload_byte, channel, payload_length, is_last,
                                  status_t'(status)});
            if (in_valid && in_ready)
            begin
                sb.note_byte(rx_byte, first_in_window, link_error);
                bytes_in++;
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // The receiver cycles through always ready, random stalls, a fixed duty pattern and random stall bursts.
    always @(negedge clk)
    begin
        cycle_no++;
        case ((cycle_no / 300) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ((cycle_no % 7) < 4);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 7);
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic err);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                rx_byte <= 8'($urandom);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= b;
        first_in_window <= first;
        link_error <= err;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drops valid and waits for every expected request, then lets the output register
    // settle before anything touches the configuration.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (3)
            @(negedge clk);
    endtask

    task automatic write_limit_idle(input logic [LEN_W-1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        sb.write_limit(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 15'($urandom);
        settings_used++;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
    endtask

    task automatic send_packet(input logic [LEN_W-1:0] lim);
        int unsigned sel;
        int unsigned npay;
        int unsigned nbytes;
        int unsigned cut;
        int unsigned abort_kind;
        int unsigned cap;
        logic [LEN_W-1:0] len;
        logic [7:0] hdr[4];
        sel = $urandom_range(0, 99);
        cap = (lim < 5) ? 5 : int'(lim);
        if (sel < 5)
            len = '0;
        else if (sel < 10)
            len = HDR_BYTES;
        else if (sel < 15)
            len = 15'($urandom_range(1, 3));
        else if (sel < 22)
            len = (lim < 15'h7FFF) ? 15'($urandom_range(int'(lim) + 1, 32767)) : 15'h7FFF;
        else if (sel < 25)
            len = 15'($urandom_range(5, 32767));
        else if (sel < 28)
            len = 15'($urandom_range(5, (cap > 300) ? 300 : cap));
        else
            len = 15'($urandom_range(5, (cap > 40) ? 40 : cap));
        hdr[0] = len[7:0];
        hdr[1] = {1'($urandom), len[14:8]};
        hdr[2] = 8'($urandom);
        hdr[3] = 8'($urandom);
        npay = (len > HDR_BYTES && len <= lim) ? int'(len) - 4 : 0;
        // Long packets are cut short; the next first byte restarts the parse mid-packet.
        nbytes = (npay > 300) ? 4 + $urandom_range(10, 40) : 4 + npay;
        abort_kind = 0;
        cut = 0;
        if ($urandom_range(0, 99) < 12)
        begin
            abort_kind = $urandom_range(1, 2);
            cut = $urandom_range(0, nbytes - 1);
        end
        for (int i = 0; i < nbytes; i++)
        begin
            if (abort_kind == 2 && i == cut)
                break;
            send_byte((i < 4) ? hdr[i] : 8'($urandom), i == 0, abort_kind == 1 && i == cut);
            if (abort_kind == 1 && i == cut)
                break;
        end
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        first_in_window = 1'b0;
        link_error = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        out_ready = 1'b0;
        bytes_in = 0;
        quiet_cycles = 0;
        burst_left = 0;
        cycle_no = 0;
        stall_left = 0;
        settings_used = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset limit of 512.
        send_byte(8'hA5, 1'b0, 1'b1);       // outside a packet, error ignored
        send_byte(8'h00, 1'b1, 1'b0);       // length zero
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h04, 1'b1, 1'b0);       // header only, continuation bit set
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h02, 1'b1, 1'b0);       // length shorter than the header
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h06, 1'b1, 1'b0);       // two payload bytes on channel 255
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h77, 1'b0, 1'b0);       // after the end, ignored
        send_byte(8'h3C, 1'b1, 1'b1);       // first byte fails
        send_byte(8'h10, 1'b1, 1'b0);       // failure inside the header
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h20, 1'b1, 1'b0);       // header interrupted by a new window
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h58, 1'b1, 1'b0);       // 600 is above the limit
        send_byte(8'h82, 1'b0, 1'b0);
        send_byte(8'h09, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);

        random_base = bytes_in;
        phase_idx = 0;
        while (bytes_in - random_base < RANDOM_BYTES)
        begin
            case (phase_idx)
                0: cur_limit = 15'h7FFF;
                1: cur_limit = 15'd4;
                2: cur_limit = 15'd3;
                3: cur_limit = LENGTH_LIMIT_RESET;
                default:
                    cur_limit = $urandom_range(0, 1) ? 15'($urandom)
                                                     : 15'($urandom_range(5, 200));
            endcase
            write_limit_idle(cur_limit);
            phase_end = bytes_in + PHASE_BYTES;
            while (bytes_in < phase_end && bytes_in - random_base < RANDOM_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_packet(cur_limit);
            end
            phase_idx++;
        end

        drain();
        repeat (5)
            @(posedge clk);
        $display("Sent %0d bytes over %0d length limits.", bytes_in, settings_used + 1);
        $display("Requests seen: %0d data, %0d empty, %0d bad length, %0d link error.",
                 sb.seen[ST_DATA], sb.seen[ST_EMPTY], sb.seen[ST_BADLEN], sb.seen[ST_LINKERR]);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/shtp_pkg.sv
rtl/shtp_parse.sv
rtl/shtp_out_reg.sv
rtl/shtp_packet_deframer_top.sv
rtl/shtp_checker.sv
bench/deframer_tb_pkg.sv
bench/tb_top.sv
